FILE: rtl/mme_pkg.sv
// Package for the modular exponentiation block: widths, register indexes and
// the control and status types shared by the sequencer and the multiplier.
// Depends on nothing.
`timescale 1ns / 1ps
package mme_pkg;

   localparam int MOD_WIDTH_DEF = 32;
   localparam int BASE_WIDTH    = 32;
   localparam int EXP_WIDTH     = 32;
   localparam int POWER_WIDTH   = 32;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int STEP_WIDTH    = $clog2(BASE_WIDTH + 1);

   // Register index, taken from address bit 2 (byte addresses 0 and 4).
   localparam logic REG_EXPONENT = 1'b0;
   localparam logic REG_MODULUS  = 1'b1;

   typedef struct packed {
      logic start;
      logic wide;   // operand a is a full base word rather than a residue
   } mul_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

FILE: rtl/mme_mulmod.sv
// Bit-serial interleaved modular multiplier: one bit of operand a per cycle.
// Depends on mme_pkg.
`timescale 1ns / 1ps
module mme_mulmod import mme_pkg::*; #(
   parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mul_ctrl_type          ctrl,
   input  logic [BASE_WIDTH-1:0] a_in,
   input  logic [MOD_WIDTH-1:0]  b_in,
   input  logic [MOD_WIDTH-1:0]  m_in,
   output mul_stat_type          stat,
   output logic [MOD_WIDTH-1:0]  result
);

   localparam int ALIGN = BASE_WIDTH - MOD_WIDTH;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_WIDTH-1:0] steps_ff, steps_in;
   logic [BASE_WIDTH-1:0] a_ff, a_in_next;
   logic [MOD_WIDTH-1:0]  b_ff, b_in_next;
   logic [MOD_WIDTH-1:0]  m_ff, m_in_next;
   logic [MOD_WIDTH-1:0]  r_ff, r_in;

   logic [MOD_WIDTH+1:0]  sum;
   logic [MOD_WIDTH+2:0]  diff1;
   logic [MOD_WIDTH+2:0]  diff2;
   logic [MOD_WIDTH-1:0]  r_step;

   // r < m and b < m, so 2r + b < 3m and at most two subtractions of m remain.
   always_comb begin
      sum   = {1'b0, r_ff, 1'b0} + (a_ff[BASE_WIDTH-1] ? {2'b00, b_ff} : '0);
      diff1 = {1'b0, sum} - {3'b000, m_ff};
      diff2 = {1'b0, sum} - {2'b00, m_ff, 1'b0};
      if (!diff2[MOD_WIDTH+2]) begin
         r_step = diff2[MOD_WIDTH-1:0];
      end else if (!diff1[MOD_WIDTH+2]) begin
         r_step = diff1[MOD_WIDTH-1:0];
      end else begin
         r_step = sum[MOD_WIDTH-1:0];
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      steps_in  = steps_ff;
      a_in_next = a_ff;
      b_in_next = b_ff;
      m_in_next = m_ff;
      r_in      = r_ff;
      if (ctrl.start) begin
         busy_in   = 1'b1;
         r_in      = '0;
         b_in_next = b_in;
         m_in_next = m_in;
         if (ctrl.wide) begin
            a_in_next = a_in;
            steps_in  = STEP_WIDTH'(BASE_WIDTH);
         end else begin
            a_in_next = a_in << ALIGN;
            steps_in  = STEP_WIDTH'(MOD_WIDTH);
         end
      end else if (busy_ff) begin
         r_in      = r_step;
         a_in_next = a_ff << 1;
         steps_in  = steps_ff - 1'b1;
         if (steps_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      steps_ff <= steps_in;
      a_ff     <= a_in_next;
      b_ff     <= b_in_next;
      m_ff     <= m_in_next;
      r_ff     <= r_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = r_ff;

endmodule

FILE: rtl/mme_csr.sv
// Configuration registers (exponent and modulus) behind the APB-style port.
// Depends on mme_pkg.
`timescale 1ns / 1ps
module mme_csr import mme_pkg::*; #(
   parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [EXP_WIDTH-1:0]  exponent,
   output logic [MOD_WIDTH-1:0]  modulus
);

   logic [EXP_WIDTH-1:0] exponent_ff;
   logic [MOD_WIDTH-1:0] modulus_ff;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= EXP_WIDTH'(1);
         modulus_ff  <= MOD_WIDTH'(2);
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_EXPONENT: exponent_ff <= csr_pwdata[EXP_WIDTH-1:0];
            REG_MODULUS:  modulus_ff  <= csr_pwdata[MOD_WIDTH-1:0];
            default:      exponent_ff <= exponent_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_EXPONENT: csr_prdata = CSR_DATA_W'(exponent_ff);
         REG_MODULUS:  csr_prdata = CSR_DATA_W'(modulus_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign exponent = exponent_ff;
   assign modulus  = modulus_ff;

endmodule

FILE: rtl/modular_exponentiation.sv
// Sequence: the base is first reduced by a bit-serial multiplication, then
// one bit-serial multiplication follows per set exponent bit and one squaring
// per bit below the top set bit, with a decision state per bit and a final
// state that loads the result word.
// Throughput: one word at a time; the bit-serial multiplier sets the rate.
// Reset (synchronous, active high): exponent 1, modulus 2, sequencer idle.
`timescale 1ns / 1ps
module modular_exponentiation import mme_pkg::*; #(
   parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BASE_WIDTH-1:0]  req_base,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [POWER_WIDTH-1:0] rsp_power,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   // Sequencer states. The exponent is scanned from its least significant
   // bit upwards: a set bit multiplies the accumulator by the running square,
   // and the square is then squared again while higher set bits remain.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RED  = 3'd1;
   localparam logic [2:0] S_BIT  = 3'd2;
   localparam logic [2:0] S_MACC = 3'd3;
   localparam logic [2:0] S_SQR  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [EXP_WIDTH-1:0]   exponent;
   logic [MOD_WIDTH-1:0]   modulus;

   logic [2:0]             state_ff, state_in;
   logic [MOD_WIDTH-1:0]   acc_ff, acc_in;
   logic [MOD_WIDTH-1:0]   sq_ff, sq_in;
   logic [EXP_WIDTH-1:0]   bits_ff, bits_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POWER_WIDTH-1:0] power_ff, power_in;

   mul_ctrl_type           mul_ctrl;
   mul_stat_type           mul_stat;
   logic [BASE_WIDTH-1:0]  mul_a;
   logic [MOD_WIDTH-1:0]   mul_b;
   logic [MOD_WIDTH-1:0]   mul_result;

   logic                   mod_small;
   logic                   out_free;

   mme_csr #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .exponent    (exponent),
      .modulus     (modulus)
   );

   mme_mulmod #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mul_ctrl),
      .a_in   (mul_a),
      .b_in   (mul_b),
      .m_in   (modulus),
      .stat   (mul_stat),
      .result (mul_result)
   );

   // A modulus of 0 or 1 gives 0 for every base without any arithmetic.
   assign mod_small = (modulus[MOD_WIDTH-1:1] == '0);

   // The output register may be refilled when it is empty or being taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      bits_in      = bits_ff;
      power_in     = power_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_ctrl     = '0;
      mul_a        = BASE_WIDTH'(sq_ff);
      mul_b        = sq_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (mod_small) begin
                  acc_in   = '0;
                  state_in = S_OUT;
               end else begin
                  // The base is reduced by multiplying it by one: every bit
                  // of the full word passes through the multiplier.
                  mul_ctrl.start = 1'b1;
                  mul_ctrl.wide  = 1'b1;
                  mul_a          = req_base;
                  mul_b          = MOD_WIDTH'(1);
                  state_in       = S_RED;
               end
            end
         end
         S_RED: begin
            if (mul_stat.done) begin
               sq_in    = mul_result;
               acc_in   = MOD_WIDTH'(1);
               bits_in  = exponent;
               state_in = S_BIT;
            end
         end
         S_BIT: begin
            if (bits_ff == '0) begin
               state_in = S_OUT;
            end else if (bits_ff[0]) begin
               mul_ctrl.start = 1'b1;
               mul_a          = BASE_WIDTH'(acc_ff);
               mul_b          = sq_ff;
               state_in       = S_MACC;
            end else begin
               // A clear bit below a set one: only the square moves on.
               bits_in        = bits_ff >> 1;
               mul_ctrl.start = 1'b1;
               state_in       = S_SQR;
            end
         end
         S_MACC: begin
            if (mul_stat.done) begin
               acc_in  = mul_result;
               bits_in = bits_ff >> 1;
               // The square after the top set bit is never used, so skip it.
               if (bits_ff[EXP_WIDTH-1:1] != '0) begin
                  mul_ctrl.start = 1'b1;
                  state_in       = S_SQR;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_SQR: begin
            if (mul_stat.done) begin
               sq_in    = mul_result;
               state_in = S_BIT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               power_in     = POWER_WIDTH'(acc_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      bits_ff  <= bits_in;
      power_ff <= power_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = power_ff;

endmodule

FILE: rtl/mme_checker.sv
// Port-level checks for the modular exponentiation block, bound to its top.
// Depends on mme_pkg and on the top level modular_exponentiation.
`timescale 1ns / 1ps
module mme_checker import mme_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [POWER_WIDTH-1:0] rsp_power
);

   // Nothing is offered in the cycle after a reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word offered straight after reset");

   // A stalled result word stays and keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power))
      else $error("stalled result word dropped or changed");

   // Once a word is accepted the block is busy until it has a result.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again before the current word finished");

   // The block turns ready again only as it hands its result out.
   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) && !$past(reset) |-> rsp_valid)
      else $error("block idle again without a result word");

endmodule

bind modular_exponentiation mme_checker u_mme_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_power (rsp_power)
);

FILE: tb/modexp_checker.sv
// Checker for the modular exponentiation block: follows the register port and
// both word channels, predicts each power and compares it with the result word.
// Depends on mme_pkg for widths and register indexes.
`timescale 1ns / 1ps
module modexp_checker import mme_pkg::*; #(
   parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [BASE_WIDTH-1:0]  req_base,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [POWER_WIDTH-1:0] rsp_power,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                   csr_pready,
   output int                     error_count,
   output int                     words_outstanding
);

   // Bits of the modulus register that survive a write.
   localparam logic [CSR_DATA_W-1:0] MODULUS_MASK =
      {CSR_DATA_W{1'b1}} >> (CSR_DATA_W - MOD_WIDTH);

   logic [EXP_WIDTH-1:0]   key_exponent = 1;
   logic [CSR_DATA_W-1:0]  key_modulus  = 2;
   logic [POWER_WIDTH-1:0] expected_powers[$];
   int                     mismatches = 0;

   assign error_count = mismatches;

   // Right-to-left square-and-multiply; every product fits in 64 bits.
   function automatic logic [POWER_WIDTH-1:0] predict_power(
      input logic [BASE_WIDTH-1:0] base,
      input logic [EXP_WIDTH-1:0]  exponent,
      input logic [CSR_DATA_W-1:0] modulus
   );
      logic [63:0]          accumulator;
      logic [63:0]          square;
      logic [EXP_WIDTH-1:0] bits_left;
      if (modulus < 2) begin
         return '0;
      end
      accumulator = 64'd1;
      square      = base % modulus;
      bits_left   = exponent;
      while (bits_left != 0) begin
         if (bits_left[0]) begin
            accumulator = (accumulator * square) % modulus;
         end
         bits_left = bits_left >> 1;
         square    = (square * square) % modulus;
      end
      return accumulator[POWER_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      logic [POWER_WIDTH-1:0] wanted;
      if (reset) begin
         expected_powers.delete();
         key_exponent = 1;
         key_modulus  = 2;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_EXPONENT) begin
               key_exponent = csr_pwdata[EXP_WIDTH-1:0];
            end else begin
               key_modulus = csr_pwdata & MODULUS_MASK;
            end
         end
         if (req_valid && !req_stall) begin
            expected_powers = {expected_powers,
                               predict_power(req_base, key_exponent, key_modulus)};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               mismatches++;
               $display("%0t: power word %h arrived with nothing expected",
                        $time, rsp_power);
            end else begin
               wanted = expected_powers.pop_front();
               if (rsp_power !== wanted) begin
                  mismatches++;
                  $display("%0t: power mismatch, expected %h, actual %h",
                           $time, wanted, rsp_power);
               end
            end
         end
      end
      words_outstanding <= expected_powers.size();
   end

endmodule

FILE: tb/tb_top.sv
// Top of the modular exponentiation testbench: clock, reset, key writes over
// the register port, base words and result stalls, and the verdict.
// Depends on mme_pkg, modexp_checker and the modular_exponentiation block.
`timescale 1ns / 1ps
module tb_top;
   import mme_pkg::*;

   // The random part starts no new phase once this many base words have gone in.
   localparam int ITEM_TARGET = 270;
   // Length of the single long hold-off on the result side, in cycles. It is
   // well above the cost of one full-exponent word, so the block is certain
   // to finish its word, hold the result and then stall its input.
   localparam int HOLD_CYCLES = 5000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic [BASE_WIDTH-1:0]  req_base    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic [POWER_WIDTH-1:0] rsp_power;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int error_count;
   int words_outstanding;
   int items_sent   = 0;
   int tx_idle_pct  = 16;
   int rx_idle_pct  = 63;
   bit hold_request = 1'b0;
   bit hold_taken   = 1'b0;
   int hold_left    = 0;

   modular_exponentiation dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_base    (req_base),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_power   (rsp_power),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   modexp_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_base          (req_base),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_power         (rsp_power),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .error_count       (error_count),
      .words_outstanding (words_outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // One register write: a setup cycle, an access cycle, and then one idle
   // bus cycle so that a following write never raises psel in the same step
   // in which this one lowers it. Called just after a rising edge.
   task automatic csr_write(input logic reg_index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one base word, perhaps after a few idle cycles, and returns at the
   // edge at which the block takes it. Valid stays high when the next word
   // follows at once, so it is never lowered and raised in the same step.
   // The idling pattern changes as the run passes through its three parts.
   task automatic send_word(input logic [BASE_WIDTH-1:0] base);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_base  <= base;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (items_sent == 90) begin
         tx_idle_pct = 63;
         rx_idle_pct <= 16;
      end else if (items_sent == 180) begin
         tx_idle_pct = 0;
         rx_idle_pct <= 0;
      end
   endtask

   // Stops offering and waits for every expected power to come back. The
   // count from the checker is updated at the edge, so it is first read one
   // edge after the last word was taken. Every word yields a result, so the
   // block is idle once the count is zero and the key may be rewritten.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_outstanding != 0);
   endtask

   // The result side. Outside the single long hold-off it stalls at random
   // at the rate that the current part of the run asks for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
         end
      end
   end

   initial begin : stimulus
      logic [EXP_WIDTH-1:0]  key_exponent;
      logic [CSR_DATA_W-1:0] key_modulus;
      logic [BASE_WIDTH-1:0] base;
      int                    phase_len;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The reset key (exponent one, modulus two) comes first,
      // with the extremes of the base.
      send_word(32'h0000_0000);
      send_word(32'h0000_0001);
      send_word(32'hFFFF_FFFF);
      send_word(32'h8000_0000);
      drain_results();

      // A zero exponent gives one for every base.
      csr_write(REG_EXPONENT, 32'h0000_0000);
      csr_write(REG_MODULUS, 32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'h0000_0007);
      drain_results();

      // The longest job: every exponent bit set, with the largest modulus.
      csr_write(REG_EXPONENT, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFE);
      send_word(32'hFFFF_FFFF);
      send_word(32'h0000_0002);
      send_word(32'hAAAA_AAAA);
      send_word(32'h5555_5555);
      drain_results();

      // The usual public exponent with a large prime modulus, and bases on
      // either side of the modulus so that the first reduction is exercised.
      csr_write(REG_EXPONENT, 32'h0001_0001);
      csr_write(REG_MODULUS, 32'hFFFF_FFFB);
      send_word(32'h0000_0000);
      send_word(32'h0000_0001);
      send_word(32'hFFFF_FFFA);
      send_word(32'hFFFF_FFFB);
      send_word(32'hFFFF_FFFC);
      drain_results();

      // A modulus of one or zero performs no division and returns zero.
      csr_write(REG_MODULUS, 32'h0000_0001);
      send_word(32'h1234_5678);
      send_word(32'hFFFF_FFFF);
      drain_results();
      csr_write(REG_MODULUS, 32'h0000_0000);
      send_word(32'h0000_0000);
      send_word(32'h0000_0009);
      drain_results();

      // The smallest proper modulus.
      csr_write(REG_EXPONENT, 32'h0000_0003);
      csr_write(REG_MODULUS, 32'h0000_0002);
      send_word(32'h0000_0000);
      send_word(32'h0000_0001);
      send_word(32'h0000_0003);
      drain_results();

      // Random part: a fresh key for each phase, then a batch of bases. Most
      // exponents are short so that the run stays brief; long ones get
      // shorter batches.
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:       key_exponent = $urandom;
            1:       key_exponent = 32'hFFFF_FFFF;
            2:       key_exponent = 32'h0000_0000;
            3:       key_exponent = 32'h0001_0001;
            4:       key_exponent = 32'h0000_0003;
            default: key_exponent = $urandom_range(1, 4095);
         endcase
         case ($urandom_range(0, 9))
            0:       key_modulus = 32'hFFFF_FFFF;
            1:       key_modulus = 32'h0000_0002;
            2:       key_modulus = $urandom_range(0, 1);
            3, 4:    key_modulus = $urandom_range(3, 255);
            default: key_modulus = $urandom;
         endcase
         phase_len = (key_exponent > 32'h0001_0001) ? $urandom_range(4, 8)
                                                    : $urandom_range(10, 24);
         csr_write(REG_EXPONENT, key_exponent);
         csr_write(REG_MODULUS, key_modulus);

         // Once, late in the run, the result side holds off for a long
         // stretch while this phase keeps offering words.
         if (items_sent >= 200 && !hold_request) begin
            hold_request <= 1'b1;
         end

         for (int i = 0; i < phase_len; i++) begin
            case ($urandom_range(0, 7))
               0:       base = 32'h0000_0000;
               1:       base = 32'hFFFF_FFFF;
               2:       base = key_modulus - 1;
               3:       base = key_modulus;
               4:       base = key_modulus + 1;
               5:       base = $urandom_range(0, 15);
               default: base = $urandom;
            endcase
            send_word(base);
         end
         drain_results();
      end

      // Leave room for a stray result word to show up before the verdict.
      repeat (2500) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run, in which every word
   // carries a full exponent and waits out the longest stalls.
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mme_pkg.sv
rtl/mme_mulmod.sv
rtl/mme_csr.sv
rtl/modular_exponentiation.sv
rtl/mme_checker.sv
tb/modexp_checker.sv
tb/tb_top.sv
